>>> hdl/gbfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbfs_pkg;

	localparam int GRID_ROWS_DEF = 32;
	localparam int GRID_COLS_DEF = 32;
	localparam int DIR_COUNT     = 8;

	localparam logic [1:0] STATUS_STEP    = 2'd0;
	localparam logic [1:0] STATUS_SAME    = 2'd1;
	localparam logic [1:0] STATUS_NO_PATH = 2'd2;

	localparam logic [0:0] OP_WALL  = 1'b0;
	localparam logic [0:0] OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		DELTA_ZERO  = 2'd0,
		DELTA_PLUS  = 2'd1,
		DELTA_MINUS = 2'd2
	} delta_t;

	// up, down, left, right, up-left, up-right, down-left, down-right
	function automatic delta_t dir_dr(input logic [2:0] dir);
		delta_t d;
		case (dir)
			3'd0, 3'd4, 3'd5: d = DELTA_MINUS;
			3'd1, 3'd6, 3'd7: d = DELTA_PLUS;
			default:          d = DELTA_ZERO;
		endcase
		return d;
	endfunction

	function automatic delta_t dir_dc(input logic [2:0] dir);
		delta_t d;
		case (dir)
			3'd2, 3'd4, 3'd6: d = DELTA_MINUS;
			3'd3, 3'd5, 3'd7: d = DELTA_PLUS;
			default:          d = DELTA_ZERO;
		endcase
		return d;
	endfunction

	typedef enum logic [10:0] {
		ST_CLR_RST = 11'b00000000001,
		ST_IDLE    = 11'b00000000010,
		ST_CHECK   = 11'b00000000100,
		ST_CLR     = 11'b00000001000,
		ST_INIT    = 11'b00000010000,
		ST_POP     = 11'b00000100000,
		ST_CUR     = 11'b00001000000,
		ST_NB      = 11'b00010000000,
		ST_NBW     = 11'b00100000000,
		ST_WALK    = 11'b01000000000,
		ST_WALKW   = 11'b10000000000
	} state_t;

	typedef struct packed {
		logic wr_wall;
		logic load_query;
		logic clr_step;
		logic clr_wall;
		logic init_q;
		logic pop;
		logic take_cur;
		logic nb_read;
		logic nb_skip;
		logic nb_commit;
		logic walk_next;
		logic emit_same;
		logic emit_fail;
		logic emit_step;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic start_eq_target;
		logic start_out;
		logic fifo_empty;
		logic cur_is_target;
		logic nb_out;
		logic dir_last;
		logic parent_is_start;
	} stat_t;

endpackage
`default_nettype wire

>>> hdl/gbfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gbfs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hdl/gbfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gbfs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           operation,
	input  gbfs_pkg::stat_t     st,
	output gbfs_pkg::cmd_t      cmd,
	output logic                busy
);
	gbfs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbfs_pkg::ST_CLR_RST;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != gbfs_pkg::ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			gbfs_pkg::ST_CLR_RST: begin
				cmd.clr_step = 1'b1;
				cmd.clr_wall = 1'b1;
				if (st.clr_last) state_d = gbfs_pkg::ST_IDLE;
			end
			gbfs_pkg::ST_IDLE: begin
				if (start) begin
					if (operation == gbfs_pkg::OP_WALL) begin
						cmd.wr_wall = 1'b1;
					end else begin
						cmd.load_query = 1'b1;
						state_d = gbfs_pkg::ST_CHECK;
					end
				end
			end
			gbfs_pkg::ST_CHECK: begin
				if (st.start_eq_target) begin
					cmd.emit_same = 1'b1;
					state_d = gbfs_pkg::ST_IDLE;
				end else if (st.start_out) begin
					cmd.emit_fail = 1'b1;
					state_d = gbfs_pkg::ST_IDLE;
				end else begin
					state_d = gbfs_pkg::ST_CLR;
				end
			end
			gbfs_pkg::ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = gbfs_pkg::ST_INIT;
			end
			gbfs_pkg::ST_INIT: begin
				cmd.init_q = 1'b1;
				state_d = gbfs_pkg::ST_POP;
			end
			gbfs_pkg::ST_POP: begin
				if (st.fifo_empty) begin
					cmd.emit_fail = 1'b1;
					state_d = gbfs_pkg::ST_IDLE;
				end else begin
					cmd.pop = 1'b1;
					state_d = gbfs_pkg::ST_CUR;
				end
			end
			gbfs_pkg::ST_CUR: begin
				cmd.take_cur = 1'b1;
				state_d = st.cur_is_target ? gbfs_pkg::ST_WALK : gbfs_pkg::ST_NB;
			end
			gbfs_pkg::ST_NB: begin
				if (st.nb_out) begin
					cmd.nb_skip = 1'b1;
					if (st.dir_last) state_d = gbfs_pkg::ST_POP;
				end else begin
					cmd.nb_read = 1'b1;
					state_d = gbfs_pkg::ST_NBW;
				end
			end
			gbfs_pkg::ST_NBW: begin
				cmd.nb_commit = 1'b1;
				state_d = st.dir_last ? gbfs_pkg::ST_POP : gbfs_pkg::ST_NB;
			end
			gbfs_pkg::ST_WALK: begin
				state_d = gbfs_pkg::ST_WALKW;
			end
			gbfs_pkg::ST_WALKW: begin
				if (st.parent_is_start) begin
					cmd.emit_step = 1'b1;
					state_d = gbfs_pkg::ST_IDLE;
				end else begin
					cmd.walk_next = 1'b1;
					state_d = gbfs_pkg::ST_WALK;
				end
			end
			default: state_d = gbfs_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> hdl/gbfs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module gbfs_dp #(
	parameter int GRID_ROWS = gbfs_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = gbfs_pkg::GRID_COLS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  gbfs_pkg::cmd_t  cmd,
	output gbfs_pkg::stat_t st,
	input  wire logic [4:0] cell_row,
	input  wire logic [4:0] cell_col,
	input  wire logic       cell_is_wall,
	input  wire logic [4:0] start_row,
	input  wire logic [4:0] start_col,
	input  wire logic [4:0] target_row,
	input  wire logic [4:0] target_col,
	output logic            done,
	output logic [4:0]      next_row,
	output logic [4:0]      next_col,
	output logic [1:0]      status
);
	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int P     = RW + CW;
	localparam int DEPTH = 1 << P;
	localparam logic [8:0]    ROWS9    = 9'(GRID_ROWS);
	localparam logic [8:0]    COLS9    = 9'(GRID_COLS);
	localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

	logic [4:0]   sr_q, sc_q, tr_q, tc_q;
	logic         tgt_ok_q;
	logic [P-1:0] start_idx, clr_q, cur_q, step_q, nb_q, nb_idx;
	logic [P:0]   head_q, tail_q;
	logic [2:0]   dir_q;

	logic [P-1:0] fifo_rd, par_rd;
	logic         wall_rd, vis_rd;

	logic [RW-1:0] cr, nr;
	logic [CW-1:0] cc, nc;
	gbfs_pkg::delta_t dr, dc;

	logic wall_in, sr_in, sc_in;
	logic free_nb;

	assign wall_in = (9'(cell_row) < ROWS9) && (9'(cell_col) < COLS9);
	assign sr_in   = 9'(sr_q) < ROWS9;
	assign sc_in   = 9'(sc_q) < COLS9;
	assign start_idx = {RW'(sr_q), CW'(sc_q)};

	assign cr = cur_q[P-1:CW];
	assign cc = cur_q[CW-1:0];
	assign dr = gbfs_pkg::dir_dr(dir_q);
	assign dc = gbfs_pkg::dir_dc(dir_q);

	always_comb begin
		case (dr)
			gbfs_pkg::DELTA_PLUS:  nr = cr + RW'(1);
			gbfs_pkg::DELTA_MINUS: nr = cr - RW'(1);
			default:               nr = cr;
		endcase
		case (dc)
			gbfs_pkg::DELTA_PLUS:  nc = cc + CW'(1);
			gbfs_pkg::DELTA_MINUS: nc = cc - CW'(1);
			default:               nc = cc;
		endcase
	end
	assign nb_idx = {nr, nc};

	assign st.clr_last        = &clr_q;
	assign st.start_eq_target = (sr_q == tr_q) && (sc_q == tc_q);
	assign st.start_out       = !(sr_in && sc_in);
	assign st.fifo_empty      = head_q == tail_q;
	assign st.cur_is_target   = tgt_ok_q && (fifo_rd == {RW'(tr_q), CW'(tc_q)});
	assign st.nb_out = (dr == gbfs_pkg::DELTA_MINUS && cr == '0)
	                || (dr == gbfs_pkg::DELTA_PLUS && cr == ROW_LAST)
	                || (dc == gbfs_pkg::DELTA_MINUS && cc == '0)
	                || (dc == gbfs_pkg::DELTA_PLUS && cc == COL_LAST);
	assign st.dir_last        = &dir_q;
	assign st.parent_is_start = par_rd == start_idx;

	assign free_nb = cmd.nb_commit && !wall_rd && !vis_rd;

	// rams
	logic         wall_we, wall_wd, vis_we, vis_wd, fifo_we;
	logic [P-1:0] wall_wa, vis_wa, fifo_wa, fifo_wd;

	always_comb begin
		wall_we = cmd.clr_wall || (cmd.wr_wall && wall_in);
		wall_wa = cmd.clr_wall ? clr_q : {RW'(cell_row), CW'(cell_col)};
		wall_wd = cmd.clr_wall ? 1'b0 : cell_is_wall;
		vis_we  = cmd.clr_step || cmd.init_q || free_nb;
		vis_wa  = cmd.clr_step ? clr_q : (cmd.init_q ? start_idx : nb_q);
		vis_wd  = !cmd.clr_step;
		fifo_we = cmd.init_q || free_nb;
		fifo_wa = cmd.init_q ? '0 : tail_q[P-1:0];
		fifo_wd = cmd.init_q ? start_idx : nb_q;
	end

	gbfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_wall (
		.clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
		.raddr(nb_idx), .rdata(wall_rd)
	);
	gbfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis (
		.clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
		.raddr(nb_idx), .rdata(vis_rd)
	);
	gbfs_ram #(.WIDTH(P), .DEPTH(DEPTH)) u_fifo (
		.clk(clk), .we(fifo_we), .waddr(fifo_wa), .wdata(fifo_wd),
		.raddr(head_q[P-1:0]), .rdata(fifo_rd)
	);
	gbfs_ram #(.WIDTH(P), .DEPTH(DEPTH)) u_par (
		.clk(clk), .we(free_nb), .waddr(nb_q), .wdata(cur_q),
		.raddr(step_q), .rdata(par_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
			dir_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= cmd.emit_same || cmd.emit_fail || cmd.emit_step;
			if (cmd.clr_step) clr_q <= clr_q + P'(1);
			if (cmd.init_q) begin
				head_q <= '0;
				tail_q <= (P + 1)'(1);
			end else begin
				if (cmd.pop) head_q <= head_q + (P + 1)'(1);
				if (free_nb) tail_q <= tail_q + (P + 1)'(1);
			end
			if (cmd.take_cur) dir_q <= '0;
			else if (cmd.nb_skip || cmd.nb_commit) dir_q <= dir_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			sr_q     <= start_row;
			sc_q     <= start_col;
			tr_q     <= target_row;
			tc_q     <= target_col;
			tgt_ok_q <= (9'(target_row) < ROWS9) && (9'(target_col) < COLS9);
		end
		if (cmd.take_cur) begin
			cur_q  <= fifo_rd;
			step_q <= fifo_rd;
		end else if (cmd.walk_next) begin
			step_q <= par_rd;
		end
		if (cmd.nb_read) nb_q <= nb_idx;
		if (cmd.emit_step) begin
			next_row <= 5'(step_q[P-1:CW]);
			next_col <= 5'(step_q[CW-1:0]);
			status   <= gbfs_pkg::STATUS_STEP;
		end else if (cmd.emit_same || cmd.emit_fail) begin
			next_row <= sr_q;
			next_col <= sc_q;
			status   <= cmd.emit_same ? gbfs_pkg::STATUS_SAME : gbfs_pkg::STATUS_NO_PATH;
		end
	end
endmodule
`default_nettype wire

>>> hdl/grid_bfs_next_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Breadth-first next-step finder on an 8-connected wall grid. Raise start with
// a request while busy is low. A wall write gives no result. A query gives one
// result, shown for a single cycle with done high; the receiver cannot stall
// it, so it must take it then. A query whose start equals its target or lies
// outside the grid gives its result without a search; otherwise it clears the
// visited map (all 2^(clog2(rows)+clog2(cols)) cells), then dequeues cells,
// checks the eight neighbors of each in turn and walks the parent links back
// from the target, with a single read port per memory. After reset the wall
// map is cleared the same way (one cell per cycle) with busy high.
module grid_bfs_next_step #(
	parameter int GRID_ROWS = gbfs_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = gbfs_pkg::GRID_COLS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       operation,
	input  wire logic [4:0] cell_row,
	input  wire logic [4:0] cell_col,
	input  wire logic       cell_is_wall,
	input  wire logic [4:0] start_row,
	input  wire logic [4:0] start_col,
	input  wire logic [4:0] target_row,
	input  wire logic [4:0] target_col,
	output logic            done,
	output logic [4:0]      next_row,
	output logic [4:0]      next_col,
	output logic [1:0]      status
);
	gbfs_pkg::cmd_t  cmd;
	gbfs_pkg::stat_t st;

	gbfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.st(st), .cmd(cmd), .busy(busy)
	);

	gbfs_dp #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cell_row(cell_row), .cell_col(cell_col), .cell_is_wall(cell_is_wall),
		.start_row(start_row), .start_col(start_col),
		.target_row(target_row), .target_col(target_col),
		.done(done), .next_row(next_row), .next_col(next_col), .status(status)
	);
endmodule
`default_nettype wire

>>> tb/tb_grid_bfs_next_step.sv
`timescale 1ns / 1ps
module tb_grid_bfs_next_step;

	localparam int ROWS = 32;
	localparam int COLS = 32;
	localparam int CELLS = ROWS * COLS;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [4:0] next_row;
		logic [4:0] next_col;
		logic [1:0] status;
	} step_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       operation;
	logic [4:0] cell_row;
	logic [4:0] cell_col;
	logic       cell_is_wall;
	logic [4:0] start_row;
	logic [4:0] start_col;
	logic [4:0] target_row;
	logic [4:0] target_col;
	logic       done;
	logic [4:0] next_row;
	logic [4:0] next_col;
	logic [1:0] status;

	bit    wall_cells [CELLS];
	int    parent_of [CELLS];
	step_t step_queue[$];
	int    errors;
	int    cycles;
	int    idle_pct;
	int    walls_sent;
	int    queries_sent;
	int    steps_checked;

	grid_bfs_next_step i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .cell_row(cell_row), .cell_col(cell_col),
		.cell_is_wall(cell_is_wall), .start_row(start_row), .start_col(start_col),
		.target_row(target_row), .target_col(target_col), .done(done),
		.next_row(next_row), .next_col(next_col), .status(status)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic step_t predict_step(input logic [4:0] sr, input logic [4:0] sc,
			input logic [4:0] tr, input logic [4:0] tc);
		int    drow[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
		int    dcol[8] = '{0, 0, -1, 1, -1, 1, -1, 1};
		int    fifo[CELLS];
		bit    seen[CELLS];
		int    head, tail, cur, nr, nc, nidx, from, target, walk, guard;
		step_t res;
		res.next_row = sr;
		res.next_col = sc;
		res.status = gbfs_pkg::STATUS_NO_PATH;
		if (sr == tr && sc == tc) begin
			res.status = gbfs_pkg::STATUS_SAME;
			return res;
		end
		from = sr * COLS + sc;
		target = tr * COLS + tc;
		head = 0;
		tail = 0;
		seen[from] = 1'b1;
		fifo[tail++] = from;
		while (head < tail) begin
			cur = fifo[head++];
			if (cur == target) begin
				walk = target;
				guard = 0;
				while (parent_of[walk] != from && guard < CELLS) begin
					walk = parent_of[walk];
					guard++;
				end
				res.next_row = 5'(walk / COLS);
				res.next_col = 5'(walk % COLS);
				res.status = gbfs_pkg::STATUS_STEP;
				return res;
			end
			for (int d = 0; d < 8; d++) begin
				nr = cur / COLS + drow[d];
				nc = cur % COLS + dcol[d];
				if (nr < 0 || nr >= ROWS || nc < 0 || nc >= COLS)
					continue;
				nidx = nr * COLS + nc;
				if (wall_cells[nidx] || seen[nidx])
					continue;
				fifo[tail++] = nidx;
				seen[nidx] = 1'b1;
				parent_of[nidx] = cur;
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		step_t exp_step;
		if (arst_n && done) begin
			if (step_queue.size() == 0) begin
				$error("unexpected result: next_row %0d next_col %0d status %0d",
					next_row, next_col, status);
				errors++;
			end else begin
				exp_step = step_queue.pop_front();
				steps_checked++;
				if (next_row !== exp_step.next_row) begin
					$error("next_row: expected %0d, got %0d", exp_step.next_row, next_row);
					errors++;
				end
				if (next_col !== exp_step.next_col) begin
					$error("next_col: expected %0d, got %0d", exp_step.next_col, next_col);
					errors++;
				end
				if (status !== exp_step.status) begin
					$error("status: expected %0d, got %0d", exp_step.status, status);
					errors++;
				end
			end
		end
	end

	task automatic send_request(input logic op, input logic [4:0] cr, input logic [4:0] cc,
			input logic w, input logic [4:0] sr, input logic [4:0] sc,
			input logic [4:0] tr, input logic [4:0] tc);
		start        <= 1'b1;
		operation    <= op;
		cell_row     <= cr;
		cell_col     <= cc;
		cell_is_wall <= w;
		start_row    <= sr;
		start_col    <= sc;
		target_row   <= tr;
		target_col   <= tc;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (op == gbfs_pkg::OP_WALL) begin
			wall_cells[cr * COLS + cc] = w;
			walls_sent++;
		end else begin
			step_queue.push_back(predict_step(sr, sc, tr, tc));
			queries_sent++;
		end
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	task automatic put_wall(input int r, input int c, input bit w);
		send_request(gbfs_pkg::OP_WALL, 5'(r), 5'(c), w, 5'($urandom), 5'($urandom),
			5'($urandom), 5'($urandom));
	endtask

	task automatic ask_step(input int sr, input int sc, input int tr, input int tc);
		send_request(gbfs_pkg::OP_QUERY, 5'($urandom), 5'($urandom), 1'($urandom),
			5'(sr), 5'(sc), 5'(tr), 5'(tc));
	endtask

	task automatic test_directed();
		ask_step(0, 0, 0, 0);
		ask_step(31, 31, 31, 31);
		ask_step(0, 0, 31, 31);
		ask_step(31, 0, 0, 31);
		// diagonal squeeze between two walls
		put_wall(1, 0, 1);
		put_wall(0, 1, 1);
		ask_step(0, 0, 1, 1);
		ask_step(0, 0, 2, 0);
		// target on a wall, start on a wall
		ask_step(3, 3, 1, 0);
		ask_step(1, 0, 2, 1);
		put_wall(31, 31, 1);
		put_wall(31, 31, 0);
		put_wall(1, 0, 0);
		put_wall(0, 1, 0);
		// walled-in start
		for (int d = 0; d < 9; d++)
			if (d != 4)
				put_wall(9 + d / 3, 9 + d % 3, 1);
		ask_step(10, 10, 20, 20);
		ask_step(10, 10, 10, 10);
		for (int d = 0; d < 9; d++)
			if (d != 4)
				put_wall(9 + d / 3, 9 + d % 3, 0);
	endtask

	task automatic test_random(input int pct, input int count);
		int sr, sc;
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			sr = $urandom_range(31);
			sc = $urandom_range(31);
			case ($urandom_range(9))
				0: ask_step(sr, sc, $urandom_range(31), $urandom_range(31));
				1: put_wall($urandom_range(31), $urandom_range(31), 1'($urandom));
				2: ask_step(sr, sc, sr, sc);
				default: begin
					repeat ($urandom_range(1, 4))
						put_wall(sr + $urandom_range(4) - 2 & 31,
							sc + $urandom_range(4) - 2 & 31, $urandom_range(2) != 0);
					ask_step(sr, sc, sr + $urandom_range(6) - 3 & 31,
						sc + $urandom_range(6) - 3 & 31);
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start <= 1'b0;
		operation <= gbfs_pkg::OP_WALL;
		cell_row <= '0;
		cell_col <= '0;
		cell_is_wall <= 1'b0;
		start_row <= '0;
		start_col <= '0;
		target_row <= '0;
		target_col <= '0;
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 7);
		test_random(50, 7);
		test_random(0, 7);
		test_random(17, 7);
		start <= 1'b0;
		while (step_queue.size() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		$display("Sent %0d wall writes and %0d path queries, %0d results checked,",
			walls_sent, queries_sent, steps_checked);
		$display("with sender gaps of 0, 50 and 17 percent.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
